// ===== src/scl_pkg.sv =====
`timescale 1ns / 1ps

package scl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 5;
    localparam int VAL_W    = 8;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic                    ins_en;
        logic                    del_en;
        logic signed [VAL_W-1:0] value;
    } t_ctrl;

endpackage

// ===== src/scl_cell.sv =====
`timescale 1ns / 1ps

module scl_cell (
    input  logic                            i_clk,
    input  scl_pkg::t_ctrl                  i_ctrl,
    input  logic                            i_occ,
    input  logic                            i_prev_lt,
    input  logic signed [scl_pkg::VAL_W-1:0] i_prev_val,
    input  logic signed [scl_pkg::VAL_W-1:0] i_next_val,
    output logic                            o_lt,
    output logic                            o_hit,
    output logic signed [scl_pkg::VAL_W-1:0] o_val
);

    logic signed [scl_pkg::VAL_W-1:0] r_val;
    logic signed [scl_pkg::VAL_W-1:0] n_val;

    // The held value is smaller than the broadcast value. Along the row this
    // forms a prefix, since the values are kept in ascending order.
    assign o_lt  = i_occ && (r_val < i_ctrl.value);
    assign o_hit = i_occ && !o_lt && i_prev_lt && (r_val == i_ctrl.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins_en && !o_lt) begin
            n_val = i_prev_lt ? i_ctrl.value : i_prev_val;
        end else if (i_ctrl.del_en && !o_lt) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== src/sorted_char_list.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+----------------------------
// command  | in        | i_in_valid / o_in_ready   | i_command, i_value
// result   | out       | o_out_valid / i_out_ready | o_status, o_entry_count
//
// Every cell compares its value with the broadcast value in parallel and shifts
// from a neighbor, so one item is taken per cycle unless the result is stalled.
// The result sits in an output register the cycle after the item is accepted.
// A new item is accepted whenever the output register is empty or being taken.
// Reset is synchronous and active low; it empties the list at once.

module sorted_char_list (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic signed [scl_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [scl_pkg::ENTRY_W-1:0]       o_entry_count
);

    localparam int CAP   = scl_pkg::CAPACITY;
    localparam int CNT_W = scl_pkg::CNT_W;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_out_valid;
    logic                   n_out_valid;
    scl_pkg::t_status       r_status;
    scl_pkg::t_status       n_status;

    logic                   accept;
    logic                   full;
    logic                   found;
    scl_pkg::t_ctrl         ctrl;

    logic [CAP-1:0]         occ;
    logic [CAP-1:0]         lt;
    logic [CAP-1:0]         hit;
    logic signed [scl_pkg::VAL_W-1:0] vals [CAP];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(CAP));
    assign found      = |hit;

    assign ctrl.value  = i_value;
    assign ctrl.ins_en = accept && (i_command == scl_pkg::CMD_INSERT) && !full;
    assign ctrl.del_en = accept && (i_command == scl_pkg::CMD_DELETE) && found;

    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            logic                             prev_lt;
            logic signed [scl_pkg::VAL_W-1:0] prev_val;
            logic signed [scl_pkg::VAL_W-1:0] next_val;

            assign occ[g] = (CNT_W'(g) < r_count);

            if (g == 0) begin : g_first
                assign prev_lt  = 1'b1;
                assign prev_val = i_value;
            end else begin : g_mid
                assign prev_lt  = lt[g-1];
                assign prev_val = vals[g-1];
            end

            if (g == CAP - 1) begin : g_last
                assign next_val = vals[g];
            end else begin : g_inner
                assign next_val = vals[g+1];
            end

            scl_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (ctrl),
                .i_occ      (occ[g]),
                .i_prev_lt  (prev_lt),
                .i_prev_val (prev_val),
                .i_next_val (next_val),
                .o_lt       (lt[g]),
                .o_hit      (hit[g]),
                .o_val      (vals[g])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        if (accept) begin
            n_out_valid = 1'b1;
            if (i_command == scl_pkg::CMD_INSERT) begin
                if (full) begin
                    n_status = scl_pkg::ST_FULL;
                end else begin
                    n_status = scl_pkg::ST_INSERTED;
                    n_count  = r_count + CNT_W'(1);
                end
            end else begin
                if (found) begin
                    n_status = scl_pkg::ST_REMOVED;
                    n_count  = r_count - CNT_W'(1);
                end else begin
                    n_status = scl_pkg::ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    generate
        if (CNT_W >= scl_pkg::ENTRY_W) begin : g_cnt_trunc
            assign o_entry_count = r_count[scl_pkg::ENTRY_W-1:0];
        end else begin : g_cnt_ext
            assign o_entry_count = {{(scl_pkg::ENTRY_W - CNT_W){1'b0}}, r_count};
        end
    endgenerate

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAP))
        else $error("entry count above capacity");

    a_hit_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit))
        else $error("more than one cell claims the first match");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.ins_en |=> (r_count == $past(r_count) + CNT_W'(1))
                        && (r_status == scl_pkg::ST_INSERTED))
        else $error("insert did not grow the list");

    a_delete_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.del_en |=> (r_count == $past(r_count) - CNT_W'(1))
                        && (r_status == scl_pkg::ST_REMOVED))
        else $error("delete did not shrink the list");

endmodule
